/* rtl/dmcd_pkg.sv */
// Shared constants, the request type and a helper function of the dual motor command decoder.
`default_nettype none

package dmcd_pkg;

   // Command bytes.
   localparam logic [7:0] CmdLedOff     = 8'h7a;  // 'z'
   localparam logic [7:0] CmdLedOn      = 8'h69;  // 'i'
   localparam logic [7:0] CmdGripOpen   = 8'h6f;  // 'o'
   localparam logic [7:0] CmdGripClose  = 8'h63;  // 'c'
   localparam logic [7:0] CmdGripStop   = 8'h23;  // '#'
   localparam logic [7:0] CmdElbowStop  = 8'h73;  // 's'
   localparam logic [7:0] CmdElbowUp    = 8'h65;  // 'e'
   localparam logic [7:0] CmdElbowDown  = 8'h66;  // 'f'
   localparam logic [7:0] CmdWristStop  = 8'h68;  // 'h'
   localparam logic [7:0] CmdWristUp    = 8'h70;  // 'p'
   localparam logic [7:0] CmdWristDown  = 8'h75;  // 'u'
   localparam logic [7:0] CmdBothUp     = 8'h2c;  // ','
   localparam logic [7:0] CmdBothDown   = 8'h2e;  // '.'

   // ASCII digit bounds and the tens byte that means "keep duty".
   localparam logic [7:0] CharZero      = 8'h30;
   localparam logic [7:0] CharNine      = 8'h39;
   localparam logic [7:0] CharKeepDuty  = 8'h00;

   // Gripper drive codes.
   localparam logic [1:0] GripStop      = 2'd0;
   localparam logic [1:0] GripOpen      = 2'd1;
   localparam logic [1:0] GripClose     = 2'd2;

   // Configuration register indexes.
   localparam logic [7:0] RegElbowMax   = 8'd0;
   localparam logic [7:0] RegElbowMin   = 8'd1;
   localparam logic [7:0] RegWristMax   = 8'd2;
   localparam logic [7:0] RegWristMin   = 8'd3;

   // Motor slots.
   localparam int MotorCount = 2;
   localparam int Elbow      = 0;
   localparam int Wrist      = 1;

   // Per-motor command bytes, indexed by motor slot.
   localparam logic [7:0] StopCmd [MotorCount] = '{CmdElbowStop, CmdWristStop};
   localparam logic [7:0] UpCmd   [MotorCount] = '{CmdElbowUp, CmdWristUp};
   localparam logic [7:0] DownCmd [MotorCount] = '{CmdElbowDown, CmdWristDown};

   // floor(x / 100) for x below 10000 is (x * 5243) >> 19.
   localparam logic [12:0] FracMul   = 13'd5243;
   localparam int          FracShift = 19;

   // Percent value width and request payload width.
   localparam int PctWidth  = 7;
   localparam int ReqDataW  = 24;

   // One decoded request as it travels down the pipeline.
   typedef struct packed {
      logic [7:0]            cmd;
      logic [7:0]            tens;
      logic [7:0]            units;
      logic [MotorCount-1:0] ready;
      logic [MotorCount-1:0] upper_hit;
      logic [MotorCount-1:0] lower_hit;
   } req_fields_type;

   // Digit value of an ASCII byte; anything that is not a digit counts as nine.
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] diff;
      diff = c - CharZero;
      if (c >= CharZero && c <= CharNine) begin
         return diff[3:0];
      end
      return 4'd9;
   endfunction

endpackage

`default_nettype wire

/* rtl/dual_motor_command_decoder.sv */
// Top level of the dual motor command decoder: request pipeline, duty math and latched state.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   tuser: command byte; tdata: digits, flags
// rsp_      out        rsp_tvalid / rsp_tready   tdata: latched LED, gripper, motor state
// csr_      in         csr_valid / csr_ready     csr_index register, csr_data value
//
// One request per cycle is taken while the stages can move; each result passes
// through the three register stages (input, product, state/result),
// each of which moves independently, so a stalled result does not block intake
// until all three stages are full. Reset is synchronous and active high; it clears
// the stage valids and the latched state and loads the configuration defaults.
// csr_ready is high whenever reset is low.

module dual_motor_command_decoder #(
   parameter int DUTY_WIDTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   // Request channel.
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: tens_char[7:0], units_char[7:0], elbow_ready, wrist_ready,
   // elbow_upper_hit, elbow_lower_hit, wrist_upper_hit, wrist_lower_hit, zero pad.
   input  wire [dmcd_pkg::ReqDataW-1:0] req_tdata,
   // tuser from bit 0: req_type[7:0].
   input  wire [7:0]              req_tuser,
   // Result channel.
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // tdata from bit 0: led_on, grip_cmd[1:0], elbow_dir_down, elbow_enable,
   // elbow_stopped, elbow_duty, wrist_dir_down, wrist_enable, wrist_stopped,
   // wrist_duty, command_seen, zero pad.
   output logic [((10 + 2*DUTY_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Configuration write channel.
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [7:0]              csr_index,
   input  wire [DUTY_WIDTH-1:0]   csr_data
);

   localparam int DW         = DUTY_WIDTH;
   localparam int QW         = DW - 6;
   localparam int RspW       = ((10 + 2*DW + 7) / 8) * 8;
   localparam int RecipShift = DW + 6;
   localparam int PctW       = dmcd_pkg::PctWidth;
   localparam logic [DW-1:0] RecipMul = DW'((64'd1 << RecipShift) / 64'd100);
   localparam logic [DW-1:0] DutyAllOnes = {DW{1'b1}};

   // Configuration registers.
   logic [DW-1:0] max_ff [dmcd_pkg::MotorCount];
   logic [DW-1:0] min_ff [dmcd_pkg::MotorCount];

   // max / 100 split into quotient and remainder.
   logic [QW-1:0] q_ff [dmcd_pkg::MotorCount];
   logic [6:0]    r_ff [dmcd_pkg::MotorCount];
   logic [QW-1:0] q_in [dmcd_pkg::MotorCount];
   logic [6:0]    r_in [dmcd_pkg::MotorCount];

   // Pipeline stages.
   logic                     s0_v_ff;
   dmcd_pkg::req_fields_type s0_ff;
   logic                     s1_v_ff;
   dmcd_pkg::req_fields_type s1_ff;
   logic [DW:0]              qp_ff [dmcd_pkg::MotorCount];
   logic [13:0]              rp_ff [dmcd_pkg::MotorCount];
   logic                     out_v_ff;

   // Latched state, which is also the result register.
   logic          led_ff, led_in;
   logic [1:0]    grip_ff, grip_in;
   logic          seen_ff, seen_in;
   logic [dmcd_pkg::MotorCount-1:0] dir_ff, dir_in;
   logic [dmcd_pkg::MotorCount-1:0] en_ff, en_in;
   logic [dmcd_pkg::MotorCount-1:0] stop_ff, stop_in;
   logic [DW-1:0] duty_ff [dmcd_pkg::MotorCount];
   logic [DW-1:0] duty_in [dmcd_pkg::MotorCount];

   // Handshake and stage movement.
   logic out_rdy, s1_rdy, s0_rdy;
   logic req_take, s0_move, s1_commit;
   logic [PctW-1:0] pct;

   assign out_rdy   = !out_v_ff || rsp_tready;
   assign s1_rdy    = !s1_v_ff || out_rdy;
   assign s0_rdy    = !s0_v_ff || s1_rdy;
   assign req_tready = s0_rdy && !reset;
   assign csr_ready  = !reset;
   assign req_take  = req_tvalid && req_tready;
   assign s0_move   = s0_v_ff && s1_rdy;
   assign s1_commit = s1_v_ff && out_rdy;

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s0_v_ff <= 1'b1;
         end else if (s1_rdy) begin
            s0_v_ff <= 1'b0;
         end
         if (s0_move) begin
            s1_v_ff <= 1'b1;
         end else if (out_rdy) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_commit) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
            max_ff[m] <= DutyAllOnes;
            min_ff[m] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dmcd_pkg::RegElbowMax: max_ff[dmcd_pkg::Elbow] <= csr_data;
            dmcd_pkg::RegElbowMin: min_ff[dmcd_pkg::Elbow] <= csr_data;
            dmcd_pkg::RegWristMax: max_ff[dmcd_pkg::Wrist] <= csr_data;
            dmcd_pkg::RegWristMin: min_ff[dmcd_pkg::Wrist] <= csr_data;
            default: ;
         endcase
      end
   end

   // Split each maximum into max / 100 and max % 100 by a reciprocal multiply;
   // the estimate is at most one low, so one compare and subtract fixes it.
   always_comb begin
      logic [2*DW-1:0] recip_prod;
      logic [QW-1:0]   q_est;
      logic [DW-1:0]   hundred_q;
      logic [DW-1:0]   rem_full;
      logic [7:0]      rem_est;
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         recip_prod = {{DW{1'b0}}, max_ff[m]} * {{DW{1'b0}}, RecipMul};
         q_est      = recip_prod[2*DW-1:RecipShift];
         hundred_q  = {6'b0, q_est} * DW'(100);
         rem_full   = max_ff[m] - hundred_q;
         rem_est    = rem_full[7:0];
         if (rem_est >= 8'd100) begin
            q_in[m] = q_est + QW'(1);
            r_in[m] = 7'(rem_est - 8'd100);
         end else begin
            q_in[m] = q_est;
            r_in[m] = rem_est[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         q_ff[m] <= q_in[m];
         r_ff[m] <= r_in[m];
      end
   end

   // Input register: unpack the request.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_ff.cmd       <= req_tuser;
         s0_ff.tens      <= req_tdata[7:0];
         s0_ff.units     <= req_tdata[15:8];
         s0_ff.ready     <= req_tdata[17:16];
         s0_ff.upper_hit <= {req_tdata[20], req_tdata[18]};
         s0_ff.lower_hit <= {req_tdata[21], req_tdata[19]};
      end
   end

   // Percentage from the two digit bytes.
   always_comb begin
      logic [3:0] dt;
      logic [3:0] du;
      dt  = dmcd_pkg::digit_value(s0_ff.tens);
      du  = dmcd_pkg::digit_value(s0_ff.units);
      pct = 7'({3'b0, dt} * 7'd10) + {3'b0, du};
   end

   // Product stage: quotient and remainder scaled by the percentage.
   always_ff @(posedge clock) begin
      if (s0_move) begin
         s1_ff <= s0_ff;
         for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
            qp_ff[m] <= {7'b0, q_ff[m]} * {{QW{1'b0}}, pct};
            rp_ff[m] <= {7'b0, r_ff[m]} * {7'b0, pct};
         end
      end
   end

   // Command decode and next latched state, in the command's priority order.
   always_comb begin
      logic [26:0]   frac_prod;
      logic [6:0]    frac;
      logic [DW:0]   scaled;
      logic [DW-1:0] run_duty;
      logic          run_go;
      logic          both_go;
      led_in  = led_ff;
      grip_in = grip_ff;
      seen_in = seen_ff;
      dir_in  = dir_ff;
      en_in   = en_ff;
      stop_in = stop_ff;
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         duty_in[m] = duty_ff[m];
      end

      // LED and gripper commands.
      if (s1_ff.cmd == dmcd_pkg::CmdLedOff) led_in = 1'b0;
      if (s1_ff.cmd == dmcd_pkg::CmdLedOn) led_in = 1'b1;
      if (s1_ff.cmd == dmcd_pkg::CmdGripOpen) grip_in = dmcd_pkg::GripOpen;
      if (s1_ff.cmd == dmcd_pkg::CmdGripClose) grip_in = dmcd_pkg::GripClose;
      if (s1_ff.cmd == dmcd_pkg::CmdGripStop) grip_in = dmcd_pkg::GripStop;

      // Single-motor stop and run commands.
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         frac_prod = {13'b0, rp_ff[m]} * {14'b0, dmcd_pkg::FracMul};
         frac      = frac_prod[dmcd_pkg::FracShift +: 7];
         scaled    = qp_ff[m] + {{(DW-6){1'b0}}, frac};
         if (s1_ff.tens == dmcd_pkg::CharNine && s1_ff.units == dmcd_pkg::CharNine) begin
            run_duty = max_ff[m];
         end else if (scaled[DW-1:0] < min_ff[m]) begin
            run_duty = min_ff[m];
         end else begin
            run_duty = scaled[DW-1:0];
         end
         run_go = (s1_ff.cmd == dmcd_pkg::UpCmd[m] && !s1_ff.upper_hit[m])
               || (s1_ff.cmd == dmcd_pkg::DownCmd[m] && !s1_ff.lower_hit[m]);
         if (s1_ff.ready[m]) begin
            if (s1_ff.cmd == dmcd_pkg::StopCmd[m]) begin
               led_in     = 1'b0;
               stop_in[m] = 1'b1;
               en_in[m]   = 1'b0;
               seen_in    = 1'b1;
            end
            if (run_go) begin
               dir_in[m]  = (s1_ff.cmd == dmcd_pkg::DownCmd[m]);
               led_in     = 1'b1;
               en_in[m]   = 1'b1;
               stop_in[m] = 1'b0;
               seen_in    = 1'b1;
               if (s1_ff.tens != dmcd_pkg::CharKeepDuty) begin
                  duty_in[m] = run_duty;
               end
            end
         end
      end

      // Both motors at full duty; the down move honors the lower limits.
      both_go = (&s1_ff.ready)
             && (s1_ff.cmd == dmcd_pkg::CmdBothUp
                 || (s1_ff.cmd == dmcd_pkg::CmdBothDown && !(|s1_ff.lower_hit)));
      if (both_go) begin
         for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
            dir_in[m]  = (s1_ff.cmd == dmcd_pkg::CmdBothDown);
            duty_in[m] = max_ff[m];
            en_in[m]   = 1'b1;
            stop_in[m] = 1'b0;
         end
      end
   end

   // Latched state, updated as each request retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff  <= 1'b0;
         grip_ff <= dmcd_pkg::GripStop;
         seen_ff <= 1'b0;
         dir_ff  <= '0;
         en_ff   <= '0;
         stop_ff <= '1;
         for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
            duty_ff[m] <= '0;
         end
      end else if (s1_commit) begin
         led_ff  <= led_in;
         grip_ff <= grip_in;
         seen_ff <= seen_in;
         dir_ff  <= dir_in;
         en_ff   <= en_in;
         stop_ff <= stop_in;
         for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
            duty_ff[m] <= duty_in[m];
         end
      end
   end

   // Result packing; a stopped motor shows a zero pulse width.
   always_comb begin
      logic [DW-1:0] e_duty;
      logic [DW-1:0] w_duty;
      e_duty = stop_ff[dmcd_pkg::Elbow] ? '0 : duty_ff[dmcd_pkg::Elbow];
      w_duty = stop_ff[dmcd_pkg::Wrist] ? '0 : duty_ff[dmcd_pkg::Wrist];
      rsp_tdata = RspW'({seen_ff,
                         w_duty, stop_ff[dmcd_pkg::Wrist], en_ff[dmcd_pkg::Wrist],
                         dir_ff[dmcd_pkg::Wrist],
                         e_duty, stop_ff[dmcd_pkg::Elbow], en_ff[dmcd_pkg::Elbow],
                         dir_ff[dmcd_pkg::Elbow],
                         grip_ff, led_ff});
   end

   assign rsp_tvalid = out_v_ff;

endmodule

`default_nettype wire

/* rtl/dmcd_checker.sv */
// Port-level assertions for the dual motor command decoder and their bind.
`default_nettype none

module dmcd_checker #(
   parameter int DUTY_WIDTH = 16
) (
   input wire clock,
   input wire reset,
   input wire req_tvalid,
   input wire req_tready,
   input wire rsp_tvalid,
   input wire rsp_tready,
   input wire [((10 + 2*DUTY_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int ElbowEnBit   = 4;
   localparam int ElbowStopBit = 5;
   localparam int WristEnBit   = 7 + DUTY_WIDTH;
   localparam int WristStopBit = 8 + DUTY_WIDTH;

   // A new result appears only for a request taken earlier, after the input, product and state registers.
   a_rise_follows_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result appeared without a matching request");

   // A held result keeps its payload.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Each motor is either enabled and running or locked and stopped.
   a_elbow_en_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ElbowEnBit] != rsp_tdata[ElbowStopBit])
      else $error("elbow enable and stop disagree");

   a_wrist_en_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[WristEnBit] != rsp_tdata[WristStopBit])
      else $error("wrist enable and stop disagree");

endmodule

bind dual_motor_command_decoder dmcd_checker #(.DUTY_WIDTH(DUTY_WIDTH)) u_dmcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the dual motor command decoder: stimulus, scoreboard and checks.

// Latched outputs of the decoder, packed as they appear in rsp_tdata; the last member sits at bit 0.
typedef struct packed {
   logic        seen;
   logic [15:0] wrist_duty;
   logic        wrist_stopped;
   logic        wrist_enable;
   logic        wrist_dir;
   logic [15:0] elbow_duty;
   logic        elbow_stopped;
   logic        elbow_enable;
   logic        elbow_dir;
   logic [1:0]  grip;
   logic        led;
} arm_status_type;

// Tracks the latched motor state and holds the status words still to come back.
class motor_latch_scoreboard_type;
   logic [15:0]  duty_max [dmcd_pkg::MotorCount];
   logic [15:0]  duty_min [dmcd_pkg::MotorCount];
   logic [15:0]  duty_reg [dmcd_pkg::MotorCount];
   logic         dir_down [dmcd_pkg::MotorCount];
   logic         enabled  [dmcd_pkg::MotorCount];
   logic         stopped  [dmcd_pkg::MotorCount];
   logic         led;
   logic         seen;
   logic [1:0]   grip;
   arm_status_type pending_states [$];
   int unsigned  errors;

   function new();
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         duty_max[m] = 16'hffff;
         duty_min[m] = 16'h0000;
         duty_reg[m] = 16'h0000;
         dir_down[m] = 1'b0;
         enabled[m]  = 1'b0;
         stopped[m]  = 1'b1;
      end
      led    = 1'b0;
      seen   = 1'b0;
      grip   = dmcd_pkg::GripStop;
      errors = 0;
   endfunction

   // Indexes outside the register map are dropped.
   function void write_reg(logic [7:0] idx, logic [15:0] value);
      case (idx)
         dmcd_pkg::RegElbowMax: duty_max[dmcd_pkg::Elbow] = value;
         dmcd_pkg::RegElbowMin: duty_min[dmcd_pkg::Elbow] = value;
         dmcd_pkg::RegWristMax: duty_max[dmcd_pkg::Wrist] = value;
         dmcd_pkg::RegWristMin: duty_min[dmcd_pkg::Wrist] = value;
         default: ;
      endcase
   endfunction

   // Percent digits to pulse width; a non-digit byte counts as nine.
   function logic [15:0] scaled_duty(logic [15:0] cur, logic [7:0] tens, logic [7:0] units,
                                     logic [15:0] mx, logic [15:0] mn);
      longint unsigned pct;
      longint unsigned d;
      if (tens == dmcd_pkg::CharKeepDuty) return cur;
      if (tens == dmcd_pkg::CharNine && units == dmcd_pkg::CharNine) return mx;
      pct = (tens >= dmcd_pkg::CharZero && tens <= dmcd_pkg::CharNine)
            ? longint'(tens - dmcd_pkg::CharZero) : 9;
      pct = pct * 10 + ((units >= dmcd_pkg::CharZero && units <= dmcd_pkg::CharNine)
                        ? longint'(units - dmcd_pkg::CharZero) : 9);
      d = (longint'(mx) * pct) / 100;
      if (d < longint'(mn)) d = mn;
      return d[15:0];
   endfunction

   // Apply one accepted request to the tracked state and queue the status it must produce.
   function void note_request(logic [7:0] cmd, logic [23:0] word);
      logic [7:0]  tens;
      logic [7:0]  units;
      logic [1:0]  rdy;
      logic [1:0]  up_hit;
      logic [1:0]  lo_hit;
      arm_status_type st;
      tens   = word[7:0];
      units  = word[15:8];
      rdy    = word[17:16];
      up_hit = {word[20], word[18]};
      lo_hit = {word[21], word[19]};

      case (cmd)
         dmcd_pkg::CmdLedOff:    led  = 1'b0;
         dmcd_pkg::CmdLedOn:     led  = 1'b1;
         dmcd_pkg::CmdGripOpen:  grip = dmcd_pkg::GripOpen;
         dmcd_pkg::CmdGripClose: grip = dmcd_pkg::GripClose;
         dmcd_pkg::CmdGripStop:  grip = dmcd_pkg::GripStop;
         default: ;
      endcase

      // Single motor stop and run commands, each gated by that motor's ready flag.
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         if (rdy[m]) begin
            if (cmd == dmcd_pkg::StopCmd[m]) begin
               led = 1'b0;
               stopped[m] = 1'b1;
               enabled[m] = 1'b0;
               seen = 1'b1;
            end
            if ((cmd == dmcd_pkg::UpCmd[m] && !up_hit[m])
                || (cmd == dmcd_pkg::DownCmd[m] && !lo_hit[m])) begin
               dir_down[m] = (cmd == dmcd_pkg::DownCmd[m]);
               led = 1'b1;
               enabled[m] = 1'b1;
               stopped[m] = 1'b0;
               seen = 1'b1;
               duty_reg[m] = scaled_duty(duty_reg[m], tens, units, duty_max[m], duty_min[m]);
            end
         end
      end

      // Joint moves run both motors at full duty; only the joint down move looks at limits.
      if (&rdy && (cmd == dmcd_pkg::CmdBothUp
                   || (cmd == dmcd_pkg::CmdBothDown && !(|lo_hit)))) begin
         for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
            dir_down[m] = (cmd == dmcd_pkg::CmdBothDown);
            duty_reg[m] = duty_max[m];
            enabled[m]  = 1'b1;
            stopped[m]  = 1'b0;
         end
      end

      st.led           = led;
      st.grip          = grip;
      st.elbow_dir     = dir_down[dmcd_pkg::Elbow];
      st.elbow_enable  = enabled[dmcd_pkg::Elbow];
      st.elbow_stopped = stopped[dmcd_pkg::Elbow];
      st.elbow_duty    = stopped[dmcd_pkg::Elbow] ? 16'h0000 : duty_reg[dmcd_pkg::Elbow];
      st.wrist_dir     = dir_down[dmcd_pkg::Wrist];
      st.wrist_enable  = enabled[dmcd_pkg::Wrist];
      st.wrist_stopped = stopped[dmcd_pkg::Wrist];
      st.wrist_duty    = stopped[dmcd_pkg::Wrist] ? 16'h0000 : duty_reg[dmcd_pkg::Wrist];
      st.seen          = seen;
      pending_states.push_back(st);
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compare one accepted status word with the oldest expected status.
   function void check_response(logic [47:0] data);
      arm_status_type want;
      arm_status_type got;
      if (pending_states.size() == 0) begin
         $display("%0t: status word 0x%0h arrived with none expected", $time, data);
         errors++;
         return;
      end
      want = pending_states.pop_front();
      got  = data[$bits(arm_status_type)-1:0];
      compare_field("led_on",         want.led,           got.led);
      compare_field("grip_cmd",       want.grip,          got.grip);
      compare_field("elbow_dir_down", want.elbow_dir,     got.elbow_dir);
      compare_field("elbow_enable",   want.elbow_enable,  got.elbow_enable);
      compare_field("elbow_stopped",  want.elbow_stopped, got.elbow_stopped);
      compare_field("elbow_duty",     want.elbow_duty,    got.elbow_duty);
      compare_field("wrist_dir_down", want.wrist_dir,     got.wrist_dir);
      compare_field("wrist_enable",   want.wrist_enable,  got.wrist_enable);
      compare_field("wrist_stopped",  want.wrist_stopped, got.wrist_stopped);
      compare_field("wrist_duty",     want.wrist_duty,    got.wrist_duty);
      compare_field("command_seen",   want.seen,          got.seen);
   endfunction
endclass

module tb_top;

   localparam int          DutyW      = 16;
   localparam int          RspW       = ((10 + 2*DutyW + 7) / 8) * 8;
   localparam int          CycleLimit = 400000;
   localparam logic [1:0]  NoMotor    = 2'b00;
   localparam logic [1:0]  ElbowOnly  = 2'b01;
   localparam logic [1:0]  WristOnly  = 2'b10;
   localparam logic [1:0]  BothMotors = 2'b11;
   localparam logic [7:0]  CommandSet [13] = '{dmcd_pkg::CmdLedOff, dmcd_pkg::CmdLedOn,
      dmcd_pkg::CmdGripOpen, dmcd_pkg::CmdGripClose, dmcd_pkg::CmdGripStop,
      dmcd_pkg::CmdElbowStop, dmcd_pkg::CmdElbowUp, dmcd_pkg::CmdElbowDown,
      dmcd_pkg::CmdWristStop, dmcd_pkg::CmdWristUp, dmcd_pkg::CmdWristDown,
      dmcd_pkg::CmdBothUp, dmcd_pkg::CmdBothDown};

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [dmcd_pkg::ReqDataW-1:0] req_tdata = '0;
   logic [7:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspW-1:0]     rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [7:0]          csr_index  = '0;
   logic [DutyW-1:0]    csr_data   = '0;

   bit                  idle_on    = 1'b1;
   int unsigned         cycle_count = 0;

   motor_latch_scoreboard_type tracker = new();

   dual_motor_command_decoder #(.DUTY_WIDTH(DutyW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watch all three channels on the edge where each handshake completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) tracker.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** dual_motor_command_decoder: FAILED **");
         $finish;
      end
   end

   // Result side backpressure: random stall bursts while idling is enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [23:0] req_word(logic [7:0] tens, logic [7:0] units,
                                            logic [1:0] rdy, logic [1:0] up_hit,
                                            logic [1:0] lo_hit);
      return {2'b00, lo_hit[dmcd_pkg::Wrist], up_hit[dmcd_pkg::Wrist],
              lo_hit[dmcd_pkg::Elbow], up_hit[dmcd_pkg::Elbow], rdy, units, tens};
   endfunction

   // Present one request, with an optional gap in front, and wait until it is taken.
   task automatic send_request(input logic [7:0] cmd, input logic [23:0] word);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Write all four duty limits, plus one write to an index outside the map.
   task automatic set_limits(input logic [15:0] e_max, input logic [15:0] e_min,
                             input logic [15:0] w_max, input logic [15:0] w_min);
      logic [7:0]  idx  [5];
      logic [15:0] vals [5];
      idx  = '{dmcd_pkg::RegElbowMax, dmcd_pkg::RegElbowMin, dmcd_pkg::RegWristMax,
               dmcd_pkg::RegWristMin, 8'($urandom_range(dmcd_pkg::RegWristMin + 1, 255))};
      vals = '{e_max, e_min, w_max, w_min, 16'($urandom())};
      for (int k = 0; k < 5; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every expected status word has come back.
   // The first edge lets the monitor log a request taken at the current edge.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_states.size() != 0) @(posedge clock);
   endtask

   // Mostly valid commands with digit pairs and ready motors, some noise bytes.
   task automatic send_random();
      logic [7:0] cmd;
      logic [7:0] tens;
      logic [7:0] units;
      logic [1:0] rdy;
      logic [1:0] up_hit;
      logic [1:0] lo_hit;
      cmd = ($urandom_range(0, 9) < 8) ? CommandSet[$urandom_range(0, 12)]
                                       : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       tens = dmcd_pkg::CharKeepDuty;
         1:       tens = dmcd_pkg::CharNine;
         2:       tens = 8'($urandom_range(0, 255));
         default: tens = dmcd_pkg::CharZero + 8'($urandom_range(0, 9));
      endcase
      units = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                          : dmcd_pkg::CharZero + 8'($urandom_range(0, 9));
      if (tens == dmcd_pkg::CharNine && $urandom_range(0, 1) == 1) units = dmcd_pkg::CharNine;
      for (int m = 0; m < dmcd_pkg::MotorCount; m++) begin
         rdy[m]    = ($urandom_range(0, 6) != 0);
         up_hit[m] = ($urandom_range(0, 3) == 0);
         lo_hit[m] = ($urandom_range(0, 3) == 0);
      end
      send_request(cmd, req_word(tens, units, rdy, up_hit, lo_hit));
   endtask

   task automatic run_phase(input int count);
      for (int n = 0; n < count; n++) send_random();
      drain();
   endtask

   // Directed pass with reset limits: every command, gating flags and digit corner cases.
   task automatic send_directed();
      send_request(dmcd_pkg::CmdLedOn,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, NoMotor, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdGripOpen,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, NoMotor, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdGripClose,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, NoMotor, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdGripStop,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, NoMotor, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdLedOff,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, NoMotor, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdElbowUp,
                   req_word(dmcd_pkg::CharZero + 8'd5, dmcd_pkg::CharZero, BothMotors,
                            NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdElbowDown,
                   req_word(dmcd_pkg::CharNine, dmcd_pkg::CharNine, ElbowOnly,
                            WristOnly, WristOnly));
      // Limits hit in the direction of travel block the run.
      send_request(dmcd_pkg::CmdElbowUp,
                   req_word(dmcd_pkg::CharZero + 8'd1, dmcd_pkg::CharZero, BothMotors,
                            ElbowOnly, NoMotor));
      send_request(dmcd_pkg::CmdElbowDown,
                   req_word(dmcd_pkg::CharZero + 8'd1, dmcd_pkg::CharZero, BothMotors,
                            NoMotor, ElbowOnly));
      // A zero tens byte keeps the present duty.
      send_request(dmcd_pkg::CmdElbowUp,
                   req_word(dmcd_pkg::CharKeepDuty, dmcd_pkg::CharNine, BothMotors,
                            NoMotor, NoMotor));
      // Nine followed by a non-digit is 99 percent, not full scale.
      send_request(dmcd_pkg::CmdElbowUp,
                   req_word(dmcd_pkg::CharNine, 8'h41, BothMotors, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdElbowDown,
                   req_word(8'hff, 8'h00, BothMotors, NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdElbowStop,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, BothMotors,
                            NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdElbowUp,
                   req_word(dmcd_pkg::CharZero + 8'd4, dmcd_pkg::CharZero, WristOnly,
                            NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdWristUp,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, WristOnly,
                            NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdWristDown,
                   req_word(dmcd_pkg::CharZero + 8'd3, dmcd_pkg::CharZero + 8'd7, BothMotors,
                            NoMotor, NoMotor));
      send_request(dmcd_pkg::CmdWristDown,
                   req_word(dmcd_pkg::CharZero + 8'd8, dmcd_pkg::CharZero, BothMotors,
                            NoMotor, WristOnly));
      send_request(dmcd_pkg::CmdWristUp,
                   req_word(dmcd_pkg::CharZero + 8'd8, dmcd_pkg::CharZero, BothMotors,
                            WristOnly, NoMotor));
      send_request(dmcd_pkg::CmdWristStop,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, BothMotors,
                            NoMotor, NoMotor));
      // The joint up move ignores every limit; the joint down move honors the lower ones.
      send_request(dmcd_pkg::CmdBothUp,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, BothMotors,
                            BothMotors, BothMotors));
      send_request(dmcd_pkg::CmdBothDown,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, BothMotors,
                            NoMotor, WristOnly));
      send_request(dmcd_pkg::CmdBothDown,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, BothMotors,
                            BothMotors, NoMotor));
      send_request(dmcd_pkg::CmdBothUp,
                   req_word(dmcd_pkg::CharZero, dmcd_pkg::CharZero, ElbowOnly,
                            NoMotor, NoMotor));
      // Unknown command bytes leave everything alone.
      send_request(8'h00, req_word(8'hff, 8'hff, BothMotors, NoMotor, NoMotor));
      send_request(8'hff,
                   req_word(dmcd_pkg::CharNine, dmcd_pkg::CharNine, BothMotors,
                            NoMotor, NoMotor));
      drain();
   endtask

   // Main sequence: reset, directed pass, then random phases over a range of duty limits.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      run_phase(130);

      set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_phase(140);
      set_limits(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      run_phase(140);
      // Minimum above maximum: every computed duty is lifted to the minimum.
      set_limits(16'd1000, 16'd40000, 16'h0100, 16'hffff);
      run_phase(140);
      set_limits(16'($urandom()), 16'($urandom_range(0, 2000)), 16'($urandom()),
                 16'($urandom_range(0, 2000)));
      run_phase(140);

      idle_on = 1'b0;
      set_limits(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_phase(100);
      idle_on = 1'b1;

      set_limits(16'($urandom()), 16'($urandom_range(0, 255)), 16'($urandom()),
                 16'($urandom_range(0, 255)));
      run_phase(140);

      // Closing stretch at full rate with the reset limits back in place.
      idle_on = 1'b0;
      set_limits(16'hffff, 16'h0000, 16'hffff, 16'h0000);
      run_phase(150);

      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_states.size() == 0) begin
         $display("** dual_motor_command_decoder: PASSED **");
      end else begin
         $display("** dual_motor_command_decoder: FAILED **");
      end
      $finish;
   end

endmodule

/* dual_motor_command_decoder.f */
rtl/dmcd_pkg.sv
rtl/dual_motor_command_decoder.sv
rtl/dmcd_checker.sv
test/tb_top.sv
